[hdl/rdm_request_byte_parser_defines.svh]
// Assertion macros used by the parser checker.
`ifndef RDM_REQUEST_BYTE_PARSER_DEFINES_SVH
`define RDM_REQUEST_BYTE_PARSER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define RDMP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdmp assertion failed");

// Next-cycle implication, held off during reset.
`define RDMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdmp assertion failed");

`endif

[hdl/rdmp_pkg.sv]
// Types and constants of the RDM request byte parser.
`default_nettype none

package rdmp_pkg;

    localparam int UID_W = 48;

    // parser phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_SUBSC  = 4'd1;
    localparam logic [3:0] PH_LEN    = 4'd2;
    localparam logic [3:0] PH_DEST   = 4'd3;
    localparam logic [3:0] PH_SRC    = 4'd4;
    localparam logic [3:0] PH_TRANS  = 4'd5;
    localparam logic [3:0] PH_PORT   = 4'd6;
    localparam logic [3:0] PH_MCOUNT = 4'd7;
    localparam logic [3:0] PH_SUBDEV = 4'd8;
    localparam logic [3:0] PH_CMD    = 4'd9;
    localparam logic [3:0] PH_PID    = 4'd10;
    localparam logic [3:0] PH_PLEN   = 4'd11;
    localparam logic [3:0] PH_DATA   = 4'd12;
    localparam logic [3:0] PH_CSUM   = 4'd13;

    // result kinds
    localparam logic [1:0] RK_PARAM  = 2'd0;
    localparam logic [1:0] RK_ACCEPT = 2'd1;
    localparam logic [1:0] RK_BAD    = 2'd2;

    // destination classes
    localparam logic [1:0] DC_DEVICE    = 2'd0;
    localparam logic [1:0] DC_BROADCAST = 2'd1;
    localparam logic [1:0] DC_VENDOR    = 2'd2;

    localparam logic       REQ_FRAME = 1'b1;
    localparam logic [7:0] SUB_START = 8'h01;
    localparam logic [15:0] RDM_SC   = 16'h00CC;
    localparam logic [7:0] ALL_ONES  = 8'hFF;
    localparam logic [7:0] HDR_LEN   = 8'd24;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } rdmp_item_t;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [7:0]       param_byte;
        logic [7:0]       param_index;
        logic [1:0]       dest_class;
        logic [UID_W-1:0] sender_uid;
        logic [7:0]       transaction_no;
        logic [7:0]       port_or_response;
        logic [15:0]      sub_device_no;
        logic [7:0]       command_class_code;
        logic [15:0]      pid;
        logic [7:0]       param_count;
    } rdmp_result_t;

endpackage

`default_nettype wire

[hdl/rdmp_if.sv]
// Valid/ready channel interfaces for request bytes and parser results.
`default_nettype none

interface rdmp_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
    modport mon    (input valid, input req_type, input data_byte, input ready);
endinterface

interface rdmp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  param_byte;
    logic [7:0]  param_index;
    logic [1:0]  dest_class;
    logic [47:0] sender_uid;
    logic [7:0]  transaction_no;
    logic [7:0]  port_or_response;
    logic [15:0] sub_device_no;
    logic [7:0]  command_class_code;
    logic [15:0] pid;
    logic [7:0]  param_count;

    modport source (
        output valid, input ready,
        output result_kind, output param_byte, output param_index, output dest_class,
        output sender_uid, output transaction_no, output port_or_response,
        output sub_device_no, output command_class_code, output pid, output param_count
    );
    modport sink (
        input valid, output ready,
        input result_kind, input param_byte, input param_index, input dest_class,
        input sender_uid, input transaction_no, input port_or_response,
        input sub_device_no, input command_class_code, input pid, input param_count
    );
    modport mon (
        input valid, input ready,
        input result_kind, input param_byte, input param_index, input dest_class,
        input sender_uid, input transaction_no, input port_or_response,
        input sub_device_no, input command_class_code, input pid, input param_count
    );
endinterface

`default_nettype wire

[hdl/rdm_request_byte_parser.sv]
// RDM request byte parser: takes the bytes after the RDM start code, one item
// per byte, on channel req (req_type 1 = frame start, 0 = data byte).
// Results leave on channel rsp: one item per parameter byte, then one verdict
// item (accepted or checksum bad) after the second checksum byte, each with
// the captured header fields. Frames with a bad sub start code, short length,
// nonzero message count, wrong parameter length or a foreign destination are
// dropped without a result.
// device_uid is written through cfg_we/cfg_wdata only while the parser is idle;
// the user is bound to this, the block does not enforce it. Each byte accepted
// on req enters the input register; the combinational parser step builds its
// result and the result register loads it. Throughput: one byte per cycle
// while rsp does not stall. When rsp stalls, the result register holds;
// the byte that would produce the next result waits in the input register and
// req.ready drops, while bytes that produce no result keep flowing.
// Reset clears device_uid to zero and puts the parser in idle, where bytes
// are ignored until a frame start arrives.
`default_nettype none

module rdm_request_byte_parser
    import rdmp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [UID_W-1:0] cfg_wdata,
    rdmp_in_if.sink               req,
    rdmp_out_if.source            rsp
);

    logic [UID_W-1:0] device_uid_reg;
    rdmp_item_t       item;
    logic             item_valid;
    logic             take;
    logic             res_load;
    logic             slot_free;
    rdmp_result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_uid_reg <= '0;
        end
        else if (cfg_we)
        begin
            device_uid_reg <= cfg_wdata;
        end
    end

    rdmp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    rdmp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .device_uid (device_uid_reg),
        .item       (item),
        .item_valid (item_valid),
        .slot_free  (slot_free),
        .take       (take),
        .res_load   (res_load),
        .res        (res)
    );

    rdmp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .slot_free (slot_free),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[hdl/rdmp_in_stage.sv]
// Input register holding one request byte item for the parser core.
`default_nettype none

module rdmp_in_stage
    import rdmp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rdmp_in_if.sink         req,
    input  wire logic       take,
    output rdmp_item_t      item,
    output logic            item_valid
);

    logic       valid_reg;
    logic       valid_next;
    rdmp_item_t item_reg;

    assign req.ready  = !valid_reg || take;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.valid && req.ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.req_type  <= req.req_type;
            item_reg.data_byte <= req.data_byte;
        end
    end

endmodule

`default_nettype wire

[hdl/rdmp_core.sv]
// Parser state machine: header capture, address match, checksum, result build.
`default_nettype none

module rdmp_core
    import rdmp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [UID_W-1:0] device_uid,
    input  wire rdmp_item_t       item,
    input  wire logic             item_valid,
    input  wire logic             slot_free,
    output logic                  take,
    output logic                  res_load,
    output rdmp_result_t          res
);

    logic [3:0]       phase_reg, phase_next;
    logic [7:0]       count_reg, count_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       rx_hi_reg, rx_hi_next;
    logic             m_dev_reg, m_dev_next;
    logic             m_bc_reg, m_bc_next;
    logic             m_vnd_reg, m_vnd_next;
    logic [7:0]       len_reg, len_next;
    logic [UID_W-1:0] src_reg, src_next;
    logic [7:0]       trans_reg, trans_next;
    logic [7:0]       port_reg, port_next;
    logic [15:0]      subdev_reg, subdev_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [15:0]      pid_reg, pid_next;
    logic [7:0]       pcount_reg, pcount_next;

    logic [7:0]  b;
    logic [7:0]  cnt_inc;
    logic [7:0]  own;
    logic [15:0] expect_sum;
    logic        emit;
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic [7:0]  pidx;

    assign b          = item.data_byte;
    assign cnt_inc    = count_reg + 8'd1;
    assign expect_sum = sum_reg + RDM_SC;

    // a result comes from every data byte and from the second checksum byte
    assign emit = item_valid && (item.req_type != REQ_FRAME)
                  && ((phase_reg == PH_DATA) || ((phase_reg == PH_CSUM) && (count_reg != 8'd0)));
    assign take     = item_valid && (!emit || slot_free);
    assign res_load = emit && slot_free;

    always_comb
    begin
        case (count_reg[2:0])
            3'd0:    own = device_uid[47:40];
            3'd1:    own = device_uid[39:32];
            3'd2:    own = device_uid[31:24];
            3'd3:    own = device_uid[23:16];
            3'd4:    own = device_uid[15:8];
            3'd5:    own = device_uid[7:0];
            default: own = 8'd0;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        rx_hi_next  = rx_hi_reg;
        m_dev_next  = m_dev_reg;
        m_bc_next   = m_bc_reg;
        m_vnd_next  = m_vnd_reg;
        len_next    = len_reg;
        src_next    = src_reg;
        trans_next  = trans_reg;
        port_next   = port_reg;
        subdev_next = subdev_reg;
        cmd_next    = cmd_reg;
        pid_next    = pid_reg;
        pcount_next = pcount_reg;
        kind        = RK_PARAM;
        pbyte       = 8'd0;
        pidx        = 8'd0;

        if (take && (item.req_type == REQ_FRAME))
        begin
            phase_next = PH_SUBSC;
            count_next = 8'd0;
            sum_next   = 16'd0;
            rx_hi_next = 8'd0;
            m_dev_next = 1'b1;
            m_bc_next  = 1'b1;
            m_vnd_next = 1'b1;
            len_next   = 8'd0;
        end
        else if (take)
        begin
            if ((phase_reg >= PH_SUBSC) && (phase_reg < PH_CSUM))
            begin
                sum_next = sum_reg + {8'd0, b};
            end
            case (phase_reg)
                PH_SUBSC:
                begin
                    phase_next = (b == SUB_START) ? PH_LEN : PH_IDLE;
                end
                PH_LEN:
                begin
                    if (b >= HDR_LEN)
                    begin
                        len_next   = b;
                        phase_next = PH_DEST;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DEST:
                begin
                    if (b != own)
                    begin
                        m_dev_next = 1'b0;
                    end
                    if (b != ALL_ONES)
                    begin
                        m_bc_next = 1'b0;
                    end
                    // vendorcast: manufacturer bytes match, device part all ones
                    if (count_reg < 8'd2)
                    begin
                        if (b != own)
                        begin
                            m_vnd_next = 1'b0;
                        end
                    end
                    else if (b != ALL_ONES)
                    begin
                        m_vnd_next = 1'b0;
                    end
                    count_next = cnt_inc;
                    if (cnt_inc >= 8'd6)
                    begin
                        count_next = 8'd0;
                        phase_next = (m_dev_next || m_bc_next || m_vnd_next) ? PH_SRC : PH_IDLE;
                    end
                end
                PH_SRC:
                begin
                    // six bytes MSB first shift fully into place
                    src_next   = {src_reg[UID_W-9:0], b};
                    count_next = cnt_inc;
                    if (cnt_inc >= 8'd6)
                    begin
                        count_next = 8'd0;
                        phase_next = PH_TRANS;
                    end
                end
                PH_TRANS:
                begin
                    trans_next = b;
                    phase_next = PH_PORT;
                end
                PH_PORT:
                begin
                    port_next  = b;
                    phase_next = PH_MCOUNT;
                end
                PH_MCOUNT:
                begin
                    phase_next = (b == 8'd0) ? PH_SUBDEV : PH_IDLE;
                end
                PH_SUBDEV:
                begin
                    subdev_next = {subdev_reg[7:0], b};
                    count_next  = cnt_inc;
                    if (cnt_inc >= 8'd2)
                    begin
                        count_next = 8'd0;
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    cmd_next   = b;
                    phase_next = PH_PID;
                end
                PH_PID:
                begin
                    pid_next   = {pid_reg[7:0], b};
                    count_next = cnt_inc;
                    if (cnt_inc >= 8'd2)
                    begin
                        count_next = 8'd0;
                        phase_next = PH_PLEN;
                    end
                end
                PH_PLEN:
                begin
                    if (b == (len_reg - HDR_LEN))
                    begin
                        pcount_next = b;
                        phase_next  = (b != 8'd0) ? PH_DATA : PH_CSUM;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DATA:
                begin
                    kind       = RK_PARAM;
                    pbyte      = b;
                    pidx       = count_reg;
                    count_next = cnt_inc;
                    if (cnt_inc >= pcount_reg)
                    begin
                        count_next = 8'd0;
                        phase_next = PH_CSUM;
                    end
                end
                PH_CSUM:
                begin
                    if (count_reg == 8'd0)
                    begin
                        rx_hi_next = b;
                        count_next = cnt_inc;
                    end
                    else
                    begin
                        kind       = ({rx_hi_reg, b} == expect_sum) ? RK_ACCEPT : RK_BAD;
                        count_next = 8'd0;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res.result_kind        = kind;
        res.param_byte         = pbyte;
        res.param_index        = pidx;
        res.dest_class         = m_vnd_reg ? DC_VENDOR : (m_bc_reg ? DC_BROADCAST : DC_DEVICE);
        res.sender_uid         = src_reg;
        res.transaction_no     = trans_reg;
        res.port_or_response   = port_reg;
        res.sub_device_no      = subdev_reg;
        res.command_class_code = cmd_reg;
        res.pid                = pid_reg;
        res.param_count        = pcount_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= 8'd0;
            sum_reg   <= 16'd0;
            rx_hi_reg <= 8'd0;
            m_dev_reg <= 1'b1;
            m_bc_reg  <= 1'b1;
            m_vnd_reg <= 1'b1;
            len_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            rx_hi_reg <= rx_hi_next;
            m_dev_reg <= m_dev_next;
            m_bc_reg  <= m_bc_next;
            m_vnd_reg <= m_vnd_next;
            len_reg   <= len_next;
        end
    end

    // header fields are all rewritten before any result of a frame
    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        trans_reg  <= trans_next;
        port_reg   <= port_next;
        subdev_reg <= subdev_next;
        cmd_reg    <= cmd_next;
        pid_reg    <= pid_next;
        pcount_reg <= pcount_next;
    end

endmodule

`default_nettype wire

[hdl/rdmp_out_stage.sv]
// Result register driving the output channel.
`default_nettype none

module rdmp_out_stage
    import rdmp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         res_load,
    input  wire rdmp_result_t res,
    output logic              slot_free,
    rdmp_out_if.source        rsp
);

    logic         valid_reg;
    logic         valid_next;
    rdmp_result_t res_reg;

    assign slot_free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid              = valid_reg;
    assign rsp.result_kind        = res_reg.result_kind;
    assign rsp.param_byte         = res_reg.param_byte;
    assign rsp.param_index        = res_reg.param_index;
    assign rsp.dest_class         = res_reg.dest_class;
    assign rsp.sender_uid         = res_reg.sender_uid;
    assign rsp.transaction_no     = res_reg.transaction_no;
    assign rsp.port_or_response   = res_reg.port_or_response;
    assign rsp.sub_device_no      = res_reg.sub_device_no;
    assign rsp.command_class_code = res_reg.command_class_code;
    assign rsp.pid                = res_reg.pid;
    assign rsp.param_count        = res_reg.param_count;

endmodule

`default_nettype wire

[hdl/rdmp_checker.sv]
// Port-level checks of the parser output, bound to the top level.
`default_nettype none
`include "rdm_request_byte_parser_defines.svh"

module rdmp_checker
    import rdmp_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    rdmp_out_if.source rsp
);

    `RDMP_ASSERT_NEXT(a_stall_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.result_kind) && $stable(rsp.param_byte) && $stable(rsp.param_index))
    `RDMP_ASSERT_IMPLY(a_kind_legal, clk, rst_n, rsp.valid, (rsp.result_kind == RK_PARAM) || (rsp.result_kind == RK_ACCEPT) || (rsp.result_kind == RK_BAD))
    `RDMP_ASSERT_IMPLY(a_index_bound, clk, rst_n, rsp.valid && (rsp.result_kind == RK_PARAM), rsp.param_index < rsp.param_count)
    `RDMP_ASSERT_IMPLY(a_verdict_clean, clk, rst_n, rsp.valid && (rsp.result_kind != RK_PARAM), (rsp.param_byte == 8'd0) && (rsp.param_index == 8'd0))

endmodule

bind rdm_request_byte_parser rdmp_checker u_rdmp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .rsp   (rsp)
);

`default_nettype wire

[dv/tb_rdm_request_byte_parser.sv]
// Self-checking testbench for the RDM request byte parser: framed requests in, checked results out.
module tb_rdm_request_byte_parser;
    import rdmp_pkg::*;

    localparam int SETTLE      = 8;       // cycles for the two-register pipe to empty
    localparam int LONG_HOLD   = 150;     // result-side hold-off that backs up the input
    localparam int RAND_ITEMS  = 80;
    localparam int DRAIN_LIMIT = 20000;

    typedef enum logic [2:0] {
        FLAW_NONE, FLAW_SUBSC, FLAW_SHORT, FLAW_DEST,
        FLAW_MCOUNT, FLAW_PLEN, FLAW_CSUM, FLAW_RESTART
    } flaw_t;

    typedef enum logic [1:0] {DEST_OWN, DEST_BCAST, DEST_VENDOR, DEST_OTHER} dest_t;

    // fixed verdict for a frame, or leave it to the parser copy
    typedef enum logic [1:0] {VERDICT_PRED, VERDICT_NONE, VERDICT_ACCEPT, VERDICT_BAD} verdict_t;

    typedef struct packed {
        flaw_t      flaw;
        dest_t      dest;
        logic [7:0] nparam;
        logic [7:0] fill;       // header and parameter content
        logic       fill_rand;  // random content instead of fill
        logic [3:0] lead;       // stray data bytes ahead of the frame start
        verdict_t   verdict;
    } frame_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [47:0] cfg_wdata;
    verdict_t    req_tag;

    rdmp_in_if  req_ch ();
    rdmp_out_if rsp_ch ();

    rdm_request_byte_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // parser copy
    logic [3:0]   ps_phase;
    logic [7:0]   ps_count;
    logic [15:0]  ps_sum;
    logic [15:0]  ps_rx;
    logic         ps_dev;
    logic         ps_bc;
    logic         ps_vend;
    logic [7:0]   ps_len;
    rdmp_result_t ps_hdr;
    logic [47:0]  own_uid;

    rdmp_result_t expected_results[$];

    int fail_count    = 0;
    int parsed_items  = 0;
    int frames_sent   = 0;
    int uid_settings  = 0;
    int n_param       = 0;
    int n_accept      = 0;
    int n_bad         = 0;
    bit in_gaps       = 1'b1;
    bit out_stalls    = 1'b1;
    bit hold_long     = 1'b0;

    frame_row_t directed_rows [12] = '{
        // flaw        dest         npar    fill   rnd   lead  verdict
        '{FLAW_NONE,    DEST_OWN,    8'd0,   8'h00, 1'b0, 4'd3, VERDICT_ACCEPT},
        '{FLAW_NONE,    DEST_BCAST,  8'd1,   8'hFF, 1'b0, 4'd0, VERDICT_ACCEPT},
        '{FLAW_NONE,    DEST_VENDOR, 8'd231, 8'hFF, 1'b0, 4'd0, VERDICT_ACCEPT},
        '{FLAW_CSUM,    DEST_OWN,    8'd2,   8'h00, 1'b0, 4'd0, VERDICT_BAD},
        '{FLAW_SUBSC,   DEST_OWN,    8'd1,   8'h00, 1'b1, 4'd0, VERDICT_NONE},
        '{FLAW_SHORT,   DEST_OWN,    8'd1,   8'h00, 1'b1, 4'd0, VERDICT_NONE},
        '{FLAW_DEST,    DEST_OTHER,  8'd1,   8'h00, 1'b1, 4'd0, VERDICT_NONE},
        '{FLAW_MCOUNT,  DEST_BCAST,  8'd1,   8'h00, 1'b1, 4'd0, VERDICT_NONE},
        '{FLAW_PLEN,    DEST_VENDOR, 8'd2,   8'h00, 1'b1, 4'd0, VERDICT_NONE},
        '{FLAW_RESTART, DEST_OWN,    8'd6,   8'h00, 1'b1, 4'd0, VERDICT_NONE},
        '{FLAW_NONE,    DEST_OWN,    8'd5,   8'h00, 1'b1, 4'd0, VERDICT_PRED},
        '{FLAW_CSUM,    DEST_BCAST,  8'd3,   8'h00, 1'b1, 4'd0, VERDICT_PRED}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic clear_parser(input logic [3:0] to);
        ps_phase = to;
        ps_count = '0;
        ps_sum   = '0;
        ps_rx    = '0;
        ps_dev   = 1'b1;
        ps_bc    = 1'b1;
        ps_vend  = 1'b1;
        ps_len   = '0;
        ps_hdr   = '0;
    endtask

    function automatic rdmp_result_t make_result(input logic [1:0] kind,
                                                 input logic [7:0] pbyte,
                                                 input logic [7:0] pidx);
        rdmp_result_t r;
        r = ps_hdr;
        r.result_kind = kind;
        r.param_byte  = pbyte;
        r.param_index = pidx;
        r.dest_class  = ps_vend ? DC_VENDOR : (ps_bc ? DC_BROADCAST : DC_DEVICE);
        return r;
    endfunction

    // One accepted item through the parser copy.
    task automatic parse_step(input rdmp_item_t it, output bit got, output rdmp_result_t r,
                              output bit live);
        logic [7:0]  b;
        logic [7:0]  own;
        logic [15:0] want_sum;
        b    = it.data_byte;
        got  = 1'b0;
        r    = '0;
        live = (it.req_type == REQ_FRAME) || (ps_phase != PH_IDLE);
        if (it.req_type == REQ_FRAME)
        begin
            clear_parser(PH_SUBSC);
            return;
        end
        if (ps_phase >= PH_SUBSC && ps_phase < PH_CSUM)
            ps_sum = ps_sum + {8'd0, b};
        case (ps_phase)
            PH_SUBSC:
                ps_phase = (b == SUB_START) ? PH_LEN : PH_IDLE;
            PH_LEN:
            begin
                if (b >= HDR_LEN)
                begin
                    ps_len   = b;
                    ps_phase = PH_DEST;
                end
                else
                    ps_phase = PH_IDLE;
            end
            PH_DEST:
            begin
                own = own_uid[8 * (5 - ps_count) +: 8];
                if (b != own)
                    ps_dev = 1'b0;
                if (b != ALL_ONES)
                    ps_bc = 1'b0;
                // vendorcast: manufacturer bytes match, device part all ones
                if ((ps_count < 8'd2) ? (b != own) : (b != ALL_ONES))
                    ps_vend = 1'b0;
                ps_count++;
                if (ps_count == 8'd6)
                begin
                    ps_count = '0;
                    ps_phase = (ps_dev || ps_bc || ps_vend) ? PH_SRC : PH_IDLE;
                end
            end
            PH_SRC:
            begin
                ps_hdr.sender_uid[8 * (5 - ps_count) +: 8] = b;
                ps_count++;
                if (ps_count == 8'd6)
                begin
                    ps_count = '0;
                    ps_phase = PH_TRANS;
                end
            end
            PH_TRANS:
            begin
                ps_hdr.transaction_no = b;
                ps_phase = PH_PORT;
            end
            PH_PORT:
            begin
                ps_hdr.port_or_response = b;
                ps_phase = PH_MCOUNT;
            end
            PH_MCOUNT:
                ps_phase = (b == 8'h00) ? PH_SUBDEV : PH_IDLE;
            PH_SUBDEV:
            begin
                if (ps_count == 8'd0)
                    ps_hdr.sub_device_no[15:8] = b;
                else
                    ps_hdr.sub_device_no[7:0] = b;
                ps_count++;
                if (ps_count == 8'd2)
                begin
                    ps_count = '0;
                    ps_phase = PH_CMD;
                end
            end
            PH_CMD:
            begin
                ps_hdr.command_class_code = b;
                ps_phase = PH_PID;
            end
            PH_PID:
            begin
                if (ps_count == 8'd0)
                    ps_hdr.pid[15:8] = b;
                else
                    ps_hdr.pid[7:0] = b;
                ps_count++;
                if (ps_count == 8'd2)
                begin
                    ps_count = '0;
                    ps_phase = PH_PLEN;
                end
            end
            PH_PLEN:
            begin
                if (b == ps_len - HDR_LEN)
                begin
                    ps_hdr.param_count = b;
                    ps_phase = (b != 8'h00) ? PH_DATA : PH_CSUM;
                end
                else
                    ps_phase = PH_IDLE;
            end
            PH_DATA:
            begin
                got = 1'b1;
                r   = make_result(RK_PARAM, b, ps_count);
                ps_count++;
                if (ps_count >= ps_hdr.param_count)
                begin
                    ps_count = '0;
                    ps_phase = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                if (ps_count == 8'd0)
                    ps_rx[15:8] = b;
                else
                    ps_rx[7:0] = b;
                ps_count++;
                if (ps_count == 8'd2)
                begin
                    want_sum = ps_sum + RDM_SC;
                    got      = 1'b1;
                    r        = make_result((ps_rx == want_sum) ? RK_ACCEPT : RK_BAD,
                                           8'h00, 8'h00);
                    ps_count = '0;
                    ps_phase = PH_IDLE;
                end
            end
            default:
                ps_phase = PH_IDLE;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            fail_count++;
        end
    endtask

    // Results are checked before the same edge's input is predicted; latency keeps them apart.
    always @(posedge clk)
    begin : scoreboard
        rdmp_result_t seen;
        rdmp_result_t want;
        rdmp_result_t pred;
        rdmp_item_t   it;
        bit           has;
        bit           live;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen.result_kind        = rsp_ch.result_kind;
                seen.param_byte         = rsp_ch.param_byte;
                seen.param_index        = rsp_ch.param_index;
                seen.dest_class         = rsp_ch.dest_class;
                seen.sender_uid         = rsp_ch.sender_uid;
                seen.transaction_no     = rsp_ch.transaction_no;
                seen.port_or_response   = rsp_ch.port_or_response;
                seen.sub_device_no      = rsp_ch.sub_device_no;
                seen.command_class_code = rsp_ch.command_class_code;
                seen.pid                = rsp_ch.pid;
                seen.param_count        = rsp_ch.param_count;
                case (seen.result_kind)
                    RK_PARAM:  n_param++;
                    RK_ACCEPT: n_accept++;
                    default:   n_bad++;
                endcase
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item, kind %0d", seen.result_kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", 64'(want.result_kind), 64'(seen.result_kind));
                    check_field("param_byte", 64'(want.param_byte), 64'(seen.param_byte));
                    check_field("param_index", 64'(want.param_index), 64'(seen.param_index));
                    check_field("dest_class", 64'(want.dest_class), 64'(seen.dest_class));
                    check_field("sender_uid", 64'(want.sender_uid), 64'(seen.sender_uid));
                    check_field("transaction_no", 64'(want.transaction_no),
                                64'(seen.transaction_no));
                    check_field("port_or_response", 64'(want.port_or_response),
                                64'(seen.port_or_response));
                    check_field("sub_device_no", 64'(want.sub_device_no),
                                64'(seen.sub_device_no));
                    check_field("command_class_code", 64'(want.command_class_code),
                                64'(seen.command_class_code));
                    check_field("pid", 64'(want.pid), 64'(seen.pid));
                    check_field("param_count", 64'(want.param_count), 64'(seen.param_count));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                it.req_type  = req_ch.req_type;
                it.data_byte = req_ch.data_byte;
                parse_step(it, has, pred, live);
                if (live)
                    parsed_items++;
                if (has && pred.result_kind != RK_PARAM && req_tag != VERDICT_PRED)
                begin
                    if (req_tag == VERDICT_NONE)
                        has = 1'b0;
                    else
                        pred.result_kind = (req_tag == VERDICT_ACCEPT) ? RK_ACCEPT : RK_BAD;
                end
                if (has)
                    expected_results.push_back(pred);
            end
        end
    end

    // result side: random stall per item, plus one long hold-off on request
    initial
    begin : result_sink
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
            end
            stall = out_stalls ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    // valid stays up when the next item follows with no gap
    task automatic put_item(input logic t, input logic [7:0] b, input verdict_t tag);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= t;
        req_ch.data_byte <= b;
        req_tag          <= tag;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        gap = in_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick(input frame_row_t f);
        return f.fill_rand ? 8'($urandom) : f.fill;
    endfunction

    task automatic send_frame(input frame_row_t f);
        logic [7:0]  body[$];
        logic [47:0] dst;
        logic [15:0] csum;
        logic [7:0]  v;
        int          keep;
        csum = '0;
        for (int i = 0; i < f.lead; i++)
            put_item(1'b0, 8'($urandom), f.verdict);
        v = SUB_START;
        if (f.flaw == FLAW_SUBSC)
            while (v == SUB_START)
                v = 8'($urandom);
        body.push_back(v);
        body.push_back((f.flaw == FLAW_SHORT) ? 8'($urandom_range(0, 23))
                                              : 8'(24 + f.nparam));
        case (f.dest)
            DEST_OWN:    dst = own_uid;
            DEST_BCAST:  dst = '1;
            DEST_VENDOR: dst = {own_uid[47:32], 32'hFFFF_FFFF};
            default:
            begin
                // first byte differs from ours and from all ones: no class can match
                dst = {16'($urandom), 32'($urandom)};
                v   = own_uid[47:40];
                while (v == own_uid[47:40] || v == ALL_ONES)
                    v = 8'($urandom);
                dst[47:40] = v;
            end
        endcase
        for (int i = 5; i >= 0; i--)
            body.push_back(dst[8 * i +: 8]);
        for (int i = 0; i < 8; i++)       // source UID, transaction, port
            body.push_back(pick(f));
        body.push_back((f.flaw == FLAW_MCOUNT) ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = 0; i < 5; i++)       // sub-device, command class, PID
            body.push_back(pick(f));
        body.push_back((f.flaw == FLAW_PLEN) ? 8'(f.nparam + $urandom_range(1, 255))
                                             : f.nparam);
        for (int i = 0; i < f.nparam; i++)
            body.push_back(pick(f));
        foreach (body[i])
            csum += {8'd0, body[i]};
        csum += RDM_SC;
        if (f.flaw == FLAW_CSUM)
            csum ^= 16'($urandom_range(1, 65535));
        body.push_back(csum[15:8]);
        body.push_back(csum[7:0]);
        keep = (f.flaw == FLAW_RESTART) ? $urandom_range(1, body.size() - 1) : body.size();
        put_item(REQ_FRAME, 8'($urandom), f.verdict);
        for (int i = 0; i < keep; i++)
            put_item(1'b0, body[i], f.verdict);
        frames_sent++;
    endtask

    task automatic random_frame();
        frame_row_t f;
        f.verdict   = VERDICT_PRED;
        f.fill      = '0;
        f.fill_rand = 1'b1;
        f.lead      = '0;
        f.dest      = dest_t'($urandom_range(0, 2));
        f.nparam    = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(13, 231))
                                                   : 8'($urandom_range(0, 12));
        f.flaw      = ($urandom_range(0, 99) < 70) ? FLAW_NONE
                                                   : flaw_t'($urandom_range(1, 7));
        if (f.flaw == FLAW_DEST)
            f.dest = DEST_OTHER;
        send_frame(f);
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            put_item(($urandom_range(0, 7) == 0) ? REQ_FRAME : 1'b0, 8'($urandom),
                     VERDICT_PRED);
    endtask

    task automatic wait_quiet();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_uid(input logic [47:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        own_uid = v;
        cfg_we <= 1'b0;
        @(posedge clk);
        uid_settings++;
    endtask

    initial
    begin : stimulus
        logic [47:0] uid_plan [4];
        frame_row_t  burst_row;
        int          base;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= 1'b0;
        req_ch.data_byte <= '0;
        req_tag          <= VERDICT_PRED;
        own_uid = '0;
        clear_parser(PH_IDLE);
        uid_plan[0] = '1;
        uid_plan[1] = {16'($urandom), 32'($urandom)};
        uid_plan[2] = '0;
        uid_plan[3] = {16'($urandom), 32'($urandom)};
        burst_row = '{FLAW_NONE, DEST_BCAST, 8'd40, 8'h00, 1'b1, 4'd0, VERDICT_PRED};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // device UID still at its reset value here
        uid_settings = 1;
        foreach (directed_rows[i])
            send_frame(directed_rows[i]);
        base = parsed_items;

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_quiet();
            write_uid(uid_plan[ph]);
            in_gaps    = (ph != 2);
            out_stalls = (ph != 2);
            if (ph == 1)
            begin
                // result side holds off while a long frame keeps coming
                hold_long = 1'b1;
                send_frame(burst_row);
                wait_quiet();
            end
            while (parsed_items < base + RAND_ITEMS * (ph + 1) / 4)
            begin
                if ($urandom_range(0, 9) == 0)
                    noise_burst();
                else
                    random_frame();
            end
        end

        req_ch.valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && expected_results.size() != 0; n++)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected result items never arrived", expected_results.size());
            fail_count++;
        end

        $display("Parsed %0d request items in %0d frames under %0d device UID settings",
                 parsed_items, frames_sent, uid_settings);
        $display("Checked %0d parameter bytes, %0d accepted and %0d bad-checksum verdicts",
                 n_param, n_accept, n_bad);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/rdmp_pkg.sv
hdl/rdmp_if.sv
hdl/rdmp_in_stage.sv
hdl/rdmp_core.sv
hdl/rdmp_out_stage.sv
hdl/rdm_request_byte_parser.sv
hdl/rdmp_checker.sv
dv/tb_rdm_request_byte_parser.sv
